/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks in the tail search engine. Every
// macro samples on clk and is off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define CHECK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds at the same edge as the trigger
`define CHECK_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// consequence holds at the edge after the trigger
`define CHECK_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lle_pkg.sv */
// ----------------------------------------------------------------------------
// lle_pkg
// Micro-op codes, branch conditions, step codes and the control store of
// the tail search engine.
// ----------------------------------------------------------------------------
package lle_pkg;

  localparam int OP_W   = 4;
  localparam int COND_W = 3;
  localparam int STEP_W = 3;

  // result length field width
  localparam int LIS_LEN_W = 11;

  // datapath micro-ops
  localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH       = 4'd1;
  localparam logic [OP_W-1:0] OP_WR_FIRST    = 4'd2;
  localparam logic [OP_W-1:0] OP_RD_FIRST    = 4'd3;
  localparam logic [OP_W-1:0] OP_WR_ZERO     = 4'd4;
  localparam logic [OP_W-1:0] OP_RD_LAST     = 4'd5;
  localparam logic [OP_W-1:0] OP_APPEND      = 4'd6;
  localparam logic [OP_W-1:0] OP_INIT_SEARCH = 4'd7;
  localparam logic [OP_W-1:0] OP_RD_MID      = 4'd8;
  localparam logic [OP_W-1:0] OP_WR_LO       = 4'd9;
  localparam logic [OP_W-1:0] OP_NARROW      = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT        = 4'd11;

  // branch conditions
  localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
  localparam logic [COND_W-1:0] C_IN_VALID  = 3'd1;
  localparam logic [COND_W-1:0] C_LEN_ZERO  = 3'd2;
  localparam logic [COND_W-1:0] C_KEY_LT_RD = 3'd3;
  localparam logic [COND_W-1:0] C_KEY_GT_RD = 3'd4;
  localparam logic [COND_W-1:0] C_LO_LT_HI  = 3'd5;
  localparam logic [COND_W-1:0] C_LAST      = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd7;

  // program steps
  localparam logic [STEP_W-1:0] STEP_WAIT       = 3'd0;
  localparam logic [STEP_W-1:0] STEP_START      = 3'd1;
  localparam logic [STEP_W-1:0] STEP_CHK_FIRST  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_CHK_LAST   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SEARCH     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_PROBE      = 3'd5;
  localparam logic [STEP_W-1:0] STEP_FINISH     = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT       = 3'd7;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [OP_W-1:0]   op_t;
    logic [STEP_W-1:0] tgt_t;
    logic [OP_W-1:0]   op_f;
    logic [STEP_W-1:0] tgt_f;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic len_zero;
    logic key_lt_rd;
    logic key_gt_rd;
    logic lo_lt_hi;
    logic last;
    logic out_free;
  } dp_flags_t;

  // control store
  function automatic ctrl_word_t micro_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    begin
      case (step)
        STEP_WAIT:      w = '{C_IN_VALID,  OP_LATCH,       STEP_START,
                              OP_NOP,      STEP_WAIT};
        STEP_START:     w = '{C_LEN_ZERO,  OP_WR_FIRST,    STEP_FINISH,
                              OP_RD_FIRST, STEP_CHK_FIRST};
        STEP_CHK_FIRST: w = '{C_KEY_LT_RD, OP_WR_ZERO,     STEP_FINISH,
                              OP_RD_LAST,  STEP_CHK_LAST};
        STEP_CHK_LAST:  w = '{C_KEY_GT_RD, OP_APPEND,      STEP_FINISH,
                              OP_INIT_SEARCH, STEP_SEARCH};
        STEP_SEARCH:    w = '{C_LO_LT_HI,  OP_RD_MID,      STEP_PROBE,
                              OP_WR_LO,    STEP_FINISH};
        STEP_PROBE:     w = '{C_ALWAYS,    OP_NARROW,      STEP_SEARCH,
                              OP_NOP,      STEP_SEARCH};
        STEP_FINISH:    w = '{C_LAST,      OP_NOP,         STEP_EMIT,
                              OP_NOP,      STEP_WAIT};
        STEP_EMIT:      w = '{C_OUT_FREE,  OP_EMIT,        STEP_WAIT,
                              OP_NOP,      STEP_EMIT};
        default:        w = '{C_ALWAYS,    OP_NOP,         STEP_WAIT,
                              OP_NOP,      STEP_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

/* hdl/lis_length_engine.sv */
// ----------------------------------------------------------------------------
// lis_length_engine
// Longest strictly increasing subsequence length over a stream of signed
// values, driven by a small microprogram over a tail memory.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload              | beat
//  --------+----------------------+----------------------+-----------------------
//  in      | in_valid, in_stall   | value, last          | one sequence element
//  out     | out_valid, out_stall | lis_length, overflow | one result per sequence
//
//  An element that starts a sequence is written as the first tail; else the
//  first tail is read and replaced if larger than the element; else the last
//  tail is read and the element appended, or dropped at a full store, if it is
//  larger; else p <= ceil(log2(current length)) search probes, each reading the
//  midpoint tail and narrowing the bounds, find the tail to replace. A last
//  element then goes on to the result step. Reset clears the run length, the
//  overflow mark and output valid; the tail memory needs no clearing. A stalled
//  result holds the engine in its result step until the beat is taken.
// ----------------------------------------------------------------------------
module lis_length_engine import lle_pkg::*; #(
  parameter int MAX_TAILS   = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LIS_LEN_W-1:0]   lis_length,
  output logic                   overflow
);

  dp_flags_t       flags;
  logic [OP_W-1:0] op;

  lle_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .op       (op),
    .in_stall (in_stall)
  );

  lle_dpath #(
    .MAX_TAILS   (MAX_TAILS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .in_valid   (in_valid),
    .value      (value),
    .last       (last),
    .out_stall  (out_stall),
    .flags      (flags),
    .out_valid  (out_valid),
    .lis_length (lis_length),
    .overflow   (overflow)
  );

endmodule

/* hdl/lle_seq.sv */
// ----------------------------------------------------------------------------
// lle_seq
// Step counter and control store: picks one micro-op per cycle and branches
// on a datapath flag.
// ----------------------------------------------------------------------------
module lle_seq import lle_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  dp_flags_t       flags,
  output logic [OP_W-1:0] op,
  output logic            in_stall
);

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ctrl_word_t        word;
  logic              taken;

  assign word = micro_rom(pc);

  always_comb begin
    case (word.cond)
      C_ALWAYS:    taken = 1'b1;
      C_IN_VALID:  taken = flags.in_valid;
      C_LEN_ZERO:  taken = flags.len_zero;
      C_KEY_LT_RD: taken = flags.key_lt_rd;
      C_KEY_GT_RD: taken = flags.key_gt_rd;
      C_LO_LT_HI:  taken = flags.lo_lt_hi;
      C_LAST:      taken = flags.last;
      C_OUT_FREE:  taken = flags.out_free;
      default:     taken = 1'b0;
    endcase
  end

  assign op      = taken ? word.op_t  : word.op_f;
  assign pc_next = taken ? word.tgt_t : word.tgt_f;

  // input is taken only in the wait step
  assign in_stall = (pc != STEP_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* hdl/lle_dpath.sv */
// ----------------------------------------------------------------------------
// lle_dpath
// Tail memory with registered read, search bounds, run length, overflow
// mark and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lle_dpath import lle_pkg::*; #(
  parameter int MAX_TAILS   = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [OP_W-1:0]        op,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last,
  input  logic                   out_stall,
  output dp_flags_t              flags,
  output logic                   out_valid,
  output logic [LIS_LEN_W-1:0]   lis_length,
  output logic                   overflow
);

  localparam int ADDR_W = (MAX_TAILS > 1) ? $clog2(MAX_TAILS) : 1;
  localparam int LEN_W  = $clog2(MAX_TAILS + 1);

  logic [VALUE_WIDTH-1:0] mem [MAX_TAILS];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] key;
  logic                   last_q;
  logic [LEN_W-1:0]       len;
  logic                   full;
  logic [ADDR_W-1:0]      lo;
  logic [ADDR_W-1:0]      hi;
  logic [ADDR_W-1:0]      mid_q;
  logic [ADDR_W-1:0]      mid;
  logic [ADDR_W:0]        mid_sum;
  logic [ADDR_W-1:0]      len_m1;
  logic                   at_max;
  logic                   out_free;

  logic                   we;
  logic                   re;
  logic [ADDR_W-1:0]      wa;
  logic [ADDR_W-1:0]      ra;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[ADDR_W:1];
  assign len_m1   = ADDR_W'(len - LEN_W'(1));
  assign at_max   = (len == LEN_W'(MAX_TAILS));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    case (op)
      OP_WR_FIRST, OP_WR_ZERO: begin
        we = 1'b1;
      end
      OP_RD_FIRST: begin
        re = 1'b1;
      end
      OP_RD_LAST: begin
        re = 1'b1;
        ra = len_m1;
      end
      OP_APPEND: begin
        we = !at_max;
        wa = len[ADDR_W-1:0];
      end
      OP_RD_MID: begin
        re = 1'b1;
        ra = mid;
      end
      OP_WR_LO: begin
        we = 1'b1;
        wa = lo;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= key;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_WR_FIRST: begin
          len <= LEN_W'(1);
        end
        OP_APPEND: begin
          if (at_max) begin
            full <= 1'b1;
          end else begin
            len <= len + LEN_W'(1);
          end
        end
        OP_EMIT: begin
          len  <= '0;
          full <= 1'b0;
        end
        default: begin
          len <= len;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        key    <= value;
        last_q <= last;
      end
      OP_INIT_SEARCH: begin
        lo <= '0;
        hi <= len_m1;
      end
      OP_RD_MID: begin
        mid_q <= mid;
      end
      OP_NARROW: begin
        if ($signed(rdata) < $signed(key)) begin
          lo <= mid_q + ADDR_W'(1);
        end else begin
          hi <= mid_q;
        end
      end
      OP_EMIT: begin
        lis_length <= LIS_LEN_W'(len);
        overflow   <= full;
      end
      default: begin
        key <= key;
      end
    endcase
  end

  always_comb begin
    flags.in_valid  = in_valid;
    flags.len_zero  = (len == '0);
    flags.key_lt_rd = $signed(key) < $signed(rdata);
    flags.key_gt_rd = $signed(key) > $signed(rdata);
    flags.lo_lt_hi  = (lo < hi);
    flags.last      = last_q;
    flags.out_free  = out_free;
  end

  `CHECK_ALWAYS(a_len_bound, len <= LEN_W'(MAX_TAILS), "run length above store depth")
  `CHECK_SAME(a_full_sat, full, at_max, "overflow mark without saturated length")
  `CHECK_SAME(a_emit_free, op == OP_EMIT, out_free, "result written over a waiting beat")
  `CHECK_NEXT(a_emit_clear, op == OP_EMIT, len == '0 && !full && out_valid,
              "state not cleared after result")

endmodule
